>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define MPPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mppq assertion failed");

// Clocked assertion that is also checked during reset.
`define MPPQ_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mppq assertion failed");

`endif

>>> design/mppq_pkg.sv
// ----------------------------------------------------------------------------
// mppq_pkg
// Shared codes, fixed field widths and types of the priority packet queue.
// ----------------------------------------------------------------------------
package mppq_pkg;

    localparam int ACTION_BITS      = 2;
    localparam int HANDLE_PORT_BITS = 8;
    localparam int CLASS_PORT_BITS  = 16;
    localparam int STATUS_BITS      = 2;
    localparam int LIMIT_BITS       = 7;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_ENQ     = 2'd0,
        ACT_PUTBACK = 2'd1,
        ACT_DEQ     = 2'd2,
        ACT_FLUSH   = 2'd3
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_DROP  = 2'd1,
        ST_DEQ   = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WORK = 2'b10
    } t_state;

endpackage

>>> design/mppq_in_if.sv
// ----------------------------------------------------------------------------
// mppq_in_if
// Request channel: one queue operation per item.
// ----------------------------------------------------------------------------
interface mppq_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [mppq_pkg::ACTION_BITS-1:0]         action;
    logic [mppq_pkg::HANDLE_PORT_BITS-1:0]    buffer_handle;
    logic [mppq_pkg::CLASS_PORT_BITS-1:0]     priority_class;

    modport source (output valid, action, buffer_handle, priority_class, input ready);
    modport sink   (input valid, action, buffer_handle, priority_class, output ready);
endinterface

>>> design/mppq_out_if.sv
// ----------------------------------------------------------------------------
// mppq_out_if
// Response channel: one status item per request.
// ----------------------------------------------------------------------------
interface mppq_out_if;
    logic                                     valid;
    logic                                     ready;
    logic [mppq_pkg::STATUS_BITS-1:0]         status;
    logic [mppq_pkg::HANDLE_PORT_BITS-1:0]    handle_out;

    modport source (output valid, status, handle_out, input ready);
    modport sink   (input valid, status, handle_out, output ready);
endinterface

>>> design/mppq_slot_mem.sv
// ----------------------------------------------------------------------------
// mppq_slot_mem
// Slot storage: handle memory and link memory, one write and one
// registered read port each.
// ----------------------------------------------------------------------------
module mppq_slot_mem #(
    parameter int SLOT_COUNT = 64,
    parameter int DATA_BITS  = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rd_en,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_link_ra,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_hdl_ra,
    output logic [$clog2(SLOT_COUNT)-1:0] o_link_rd,
    output logic [DATA_BITS-1:0]          o_hdl_rd,
    input  logic                          i_link_we,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_link_wa,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_link_wd,
    input  logic                          i_hdl_we,
    input  logic [$clog2(SLOT_COUNT)-1:0] i_hdl_wa,
    input  logic [DATA_BITS-1:0]          i_hdl_wd
);
    localparam int SB = $clog2(SLOT_COUNT);

    logic [SB-1:0]        r_link_mem [SLOT_COUNT];
    logic [DATA_BITS-1:0] r_hdl_mem  [SLOT_COUNT];
    logic [SB-1:0]        r_link_rd;
    logic [DATA_BITS-1:0] r_hdl_rd;

    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            r_link_mem[i_link_wa] <= i_link_wd;
        end
        if (i_hdl_we) begin
            r_hdl_mem[i_hdl_wa] <= i_hdl_wd;
        end
        if (i_rd_en) begin
            r_link_rd <= r_link_mem[i_link_ra];
            r_hdl_rd  <= r_hdl_mem[i_hdl_ra];
        end
    end

    assign o_link_rd = r_link_rd;
    assign o_hdl_rd  = r_hdl_rd;
endmodule

>>> design/mppq_wrr.sv
// ----------------------------------------------------------------------------
// mppq_wrr
// Weighted round robin class selection with the service counter.
// ----------------------------------------------------------------------------
module mppq_wrr #(
    parameter int NUM_PRIORITIES = 4,
    parameter int PRIORITY_SHIFT = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [NUM_PRIORITIES-1:0]         i_nonempty,
    input  logic                              i_advance,
    output logic [$clog2(NUM_PRIORITIES)-1:0] o_que
);
    localparam int CB   = $clog2(NUM_PRIORITIES);
    localparam int CB1  = CB + 1;
    localparam int CNTW = CB + PRIORITY_SHIFT;
    localparam int CNT1 = CNTW + 1;
    localparam int MOD  = NUM_PRIORITIES << PRIORITY_SHIFT;

    logic [CNTW-1:0] r_cnt;
    logic [CNTW-1:0] n_cnt;
    logic [CB-1:0]   que0;
    logic [CB:0]     idx;
    logic            skip;
    logic [CNTW-1:0] base;
    logic [CNTW:0]   sum;

    // Scan from the counter's class; the lowest offset with work wins.
    always_comb begin
        que0  = r_cnt[CNTW-1:PRIORITY_SHIFT];
        o_que = '0;
        skip  = 1'b0;
        idx   = '0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
            idx = {1'b0, que0} + CB1'(i);
            if (idx >= CB1'(NUM_PRIORITIES)) begin
                idx = idx - CB1'(NUM_PRIORITIES);
            end
            if (i_nonempty[idx[CB-1:0]]) begin
                o_que = idx[CB-1:0];
                skip  = (i != 0);
            end
        end
    end

    // Rebase on a skip, then advance by the weight of the served class.
    always_comb begin
        base = skip ? {o_que, {PRIORITY_SHIFT{1'b0}}} : r_cnt;
        sum  = {1'b0, base} + CNT1'(NUM_PRIORITIES) - CNT1'(o_que);
        if (sum >= CNT1'(MOD)) begin
            sum = sum - CNT1'(MOD);
        end
        n_cnt = sum[CNTW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_advance) begin
            r_cnt <= n_cnt;
        end
    end
endmodule

>>> design/multi_priority_packet_queue_core.sv
// ----------------------------------------------------------------------------
// multi_priority_packet_queue_core
// Priority FIFOs of buffer handles, linked lists in a shared slot memory.
// ----------------------------------------------------------------------------
//  channel   direction  handshake        payload
//  i_req     in         valid/ready      action, buffer_handle, priority_class
//  o_rsp     out        valid/ready      status, handle_out
//  i_cfg_*   in         write enable     queue_limit (7 bits)
//
// The accept edge issues the slot memory reads; a later edge in the work
// state writes memories and lists back and loads the response.
// Response register: the next item is accepted while a response waits; its
// write-back holds until the response slot frees up.
// Synchronous active-low reset; no clearing pass, slots are handed out by a
// fill count and then from the free list.
// ----------------------------------------------------------------------------
module multi_priority_packet_queue_core #(
    parameter int NUM_PRIORITIES = 4,
    parameter int PRIORITY_SHIFT = 2,
    parameter int SLOT_COUNT     = 64,
    parameter int HANDLE_BITS    = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [mppq_pkg::LIMIT_BITS-1:0]   i_cfg_wr_data,
    mppq_in_if.sink                           i_req,
    mppq_out_if.source                        o_rsp
);
    localparam int CB = $clog2(NUM_PRIORITIES);
    localparam int SB = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int HP = mppq_pkg::HANDLE_PORT_BITS;
    localparam int HW = (HANDLE_BITS < HP) ? HANDLE_BITS : HP;
    localparam int LB = mppq_pkg::LIMIT_BITS;
    localparam int LW = (CW > LB) ? CW : LB;
    localparam int CP = mppq_pkg::CLASS_PORT_BITS;

    mppq_pkg::t_state  r_state;
    logic [LB-1:0]     r_limit;
    logic [SB-1:0]     r_head [NUM_PRIORITIES];
    logic [SB-1:0]     r_tail [NUM_PRIORITIES];
    logic [SB-1:0]     n_head [NUM_PRIORITIES];
    logic [SB-1:0]     n_tail [NUM_PRIORITIES];
    logic [NUM_PRIORITIES-1:0] r_nonempty, n_nonempty;
    logic [CW-1:0]     r_total, n_total;
    logic [CW-1:0]     r_fill, n_fill;
    logic [SB-1:0]     r_free_head, n_free_head;

    // operation latched at accept
    mppq_pkg::t_action r_op;
    logic [HW-1:0]     r_handle;
    logic [CB-1:0]     r_cls;
    logic [SB-1:0]     r_sel_head;
    logic [SB-1:0]     r_sel_tail;
    logic              r_sel_ne;
    logic              r_pop;

    logic              r_out_valid;
    mppq_pkg::t_status r_out_status;
    logic [HP-1:0]     r_out_handle;
    mppq_pkg::t_status res_status;
    logic [HP-1:0]     res_handle;

    logic              acc;
    logic              work_go;
    mppq_pkg::t_action req_act;
    logic [CB-1:0]     clamp_cls;
    logic [CB-1:0]     acc_cls;
    logic [CB-1:0]     wrr_que;
    logic              wrr_adv;
    logic              full;
    logic              empty;
    logic [SB-1:0]     new_slot;

    logic              link_we;
    logic [SB-1:0]     link_wa, link_wd, link_ra, link_rd;
    logic              hdl_we;
    logic [HW-1:0]     hdl_rd;

    assign i_req.ready = (r_state == mppq_pkg::S_IDLE);
    assign acc         = i_req.valid && i_req.ready;
    assign req_act     = mppq_pkg::t_action'(i_req.action);
    assign work_go     = (r_state == mppq_pkg::S_WORK) && (!r_out_valid || o_rsp.ready);

    // Clamp an out-of-range class to the last one.
    always_comb begin
        if (i_req.priority_class >= CP'(NUM_PRIORITIES)) begin
            clamp_cls = CB'(NUM_PRIORITIES - 1);
        end else begin
            clamp_cls = i_req.priority_class[CB-1:0];
        end
    end

    assign acc_cls = (req_act == mppq_pkg::ACT_DEQ) ? wrr_que : clamp_cls;
    assign link_ra = (req_act == mppq_pkg::ACT_DEQ) ? r_head[acc_cls] : r_free_head;

    mppq_wrr #(
        .NUM_PRIORITIES (NUM_PRIORITIES),
        .PRIORITY_SHIFT (PRIORITY_SHIFT)
    ) u_wrr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (r_nonempty),
        .i_advance  (wrr_adv && work_go),
        .o_que      (wrr_que)
    );

    mppq_slot_mem #(
        .SLOT_COUNT (SLOT_COUNT),
        .DATA_BITS  (HW)
    ) u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_en   (acc),
        .i_link_ra (link_ra),
        .i_hdl_ra  (r_head[acc_cls]),
        .o_link_rd (link_rd),
        .o_hdl_rd  (hdl_rd),
        .i_link_we (link_we && work_go),
        .i_link_wa (link_wa),
        .i_link_wd (link_wd),
        .i_hdl_we  (hdl_we && work_go),
        .i_hdl_wa  (new_slot),
        .i_hdl_wd  (r_handle)
    );

    assign full = (LW'(r_total) >= LW'(r_limit)) || (r_total == CW'(SLOT_COUNT));
    assign empty    = (r_total == '0);
    assign new_slot = r_pop ? r_free_head : r_fill[SB-1:0];

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_total     = r_total;
        n_fill      = r_fill;
        n_free_head = r_free_head;
        link_we     = 1'b0;
        link_wa     = new_slot;
        link_wd     = r_sel_head;
        hdl_we      = 1'b0;
        wrr_adv     = 1'b0;
        res_status  = mppq_pkg::ST_OK;
        res_handle  = '0;
        case (r_op)
            mppq_pkg::ACT_ENQ, mppq_pkg::ACT_PUTBACK: begin
                if (full) begin
                    res_status = mppq_pkg::ST_DROP;
                    res_handle = HP'(r_handle);
                end else begin
                    hdl_we  = 1'b1;
                    n_total = r_total + CW'(1);
                    if (r_pop) begin
                        n_free_head = link_rd;
                    end else begin
                        n_fill = r_fill + CW'(1);
                    end
                    if (!r_sel_ne) begin
                        n_head[r_cls]     = new_slot;
                        n_tail[r_cls]     = new_slot;
                        n_nonempty[r_cls] = 1'b1;
                    end else if (r_op == mppq_pkg::ACT_PUTBACK) begin
                        link_we       = 1'b1;
                        n_head[r_cls] = new_slot;
                    end else begin
                        link_we       = 1'b1;
                        link_wa       = r_sel_tail;
                        link_wd       = new_slot;
                        n_tail[r_cls] = new_slot;
                    end
                end
            end
            mppq_pkg::ACT_DEQ: begin
                if (empty) begin
                    res_status = mppq_pkg::ST_EMPTY;
                end else begin
                    res_status = mppq_pkg::ST_DEQ;
                    res_handle = HP'(hdl_rd);
                    if (r_sel_head == r_sel_tail) begin
                        n_nonempty[r_cls] = 1'b0;
                    end else begin
                        n_head[r_cls] = link_rd;
                    end
                    // push the freed slot onto the free list
                    link_we     = 1'b1;
                    link_wa     = r_sel_head;
                    link_wd     = r_free_head;
                    n_free_head = r_sel_head;
                    n_total     = r_total - CW'(1);
                    wrr_adv     = 1'b1;
                end
            end
            default: begin
                n_nonempty = '0;
                n_total    = '0;
                n_fill     = '0;
                for (int i = 0; i < NUM_PRIORITIES; i++) begin
                    n_head[i] = '0;
                    n_tail[i] = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mppq_pkg::S_IDLE;
            r_limit     <= mppq_pkg::LIMIT_RESET;
            r_nonempty  <= '0;
            r_total     <= '0;
            r_fill      <= '0;
            r_free_head <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            case (r_state)
                mppq_pkg::S_IDLE: begin
                    if (acc) begin
                        r_state <= mppq_pkg::S_WORK;
                    end
                end
                mppq_pkg::S_WORK: begin
                    if (work_go) begin
                        r_state <= mppq_pkg::S_IDLE;
                    end
                end
                default: begin
                    r_state <= mppq_pkg::S_IDLE;
                end
            endcase
            if (work_go) begin
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_nonempty  <= n_nonempty;
                r_total     <= n_total;
                r_fill      <= n_fill;
                r_free_head <= n_free_head;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op       <= req_act;
            r_handle   <= i_req.buffer_handle[HW-1:0];
            r_cls      <= acc_cls;
            r_sel_head <= r_head[acc_cls];
            r_sel_tail <= r_tail[acc_cls];
            r_sel_ne   <= r_nonempty[acc_cls];
            r_pop      <= (r_fill != r_total);
        end
        if (work_go) begin
            r_out_status <= res_status;
            r_out_handle <= res_handle;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.handle_out = r_out_handle;
endmodule

>>> design/mppq_checker.sv
// ----------------------------------------------------------------------------
// mppq_checker
// Port-level checks of the priority packet queue core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mppq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_req_valid,
    input logic                                  i_req_ready,
    input logic                                  i_rsp_valid,
    input logic                                  i_rsp_ready,
    input logic [mppq_pkg::STATUS_BITS-1:0]      i_rsp_status,
    input logic [mppq_pkg::HANDLE_PORT_BITS-1:0] i_rsp_handle_out
);
    logic                                                       req_acc;
    logic                                                       rsp_stall;
    logic                                                       rsp_plain;
    logic [mppq_pkg::STATUS_BITS+mppq_pkg::HANDLE_PORT_BITS-1:0] rsp_word;

    assign req_acc   = i_req_valid && i_req_ready;
    assign rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign rsp_plain = i_rsp_valid && (i_rsp_status == mppq_pkg::ST_OK ||
                                       i_rsp_status == mppq_pkg::ST_EMPTY);
    assign rsp_word  = {i_rsp_status, i_rsp_handle_out};

    // one item in flight: ready drops right after an accept
    `MPPQ_ASSERT(a_one_in_flight, i_clk, i_rst_n, req_acc |=> !i_req_ready)

    // a new response only appears right after the core has worked on an item
    `MPPQ_ASSERT(a_rsp_after_work, i_clk, i_rst_n, $rose(i_rsp_valid) |-> !$past(i_req_ready))

    // no handle is reported with an accepted/flushed or empty status
    `MPPQ_ASSERT(a_no_handle, i_clk, i_rst_n, rsp_plain |-> (i_rsp_handle_out == '0))

    // a stalled response holds
    `MPPQ_ASSERT(a_rsp_hold, i_clk, i_rst_n, rsp_stall |=> (i_rsp_valid && $stable(rsp_word)))

    // reset empties the response register
    `MPPQ_ASSERT_NR(a_reset_rsp, i_clk, !i_rst_n |=> !i_rsp_valid)
endmodule

bind multi_priority_packet_queue_core mppq_checker u_mppq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_handle_out (o_rsp.handle_out)
);
